@@ design/ipcidr_pkg.sv @@
// ----------------------------------------------------------------------------
// ipcidr_pkg: shared types and constants of the range to cidr splitter
// payload structs of both channels, sequencer states and field widths
// ----------------------------------------------------------------------------
package ipcidr_pkg;

	// field widths fixed by the channel payloads
	localparam int unsigned FIELD_W        = 32;
	localparam int unsigned PREFIX_W       = 6;
	localparam int unsigned ADDR_BITS_DEF  = 32;

	// one inclusive address range
	typedef struct packed {
		logic [FIELD_W-1:0] range_first;
		logic [FIELD_W-1:0] range_last;
	} ipcidr_range_t;

	// one cidr block of the decomposition
	typedef struct packed {
		logic [FIELD_W-1:0]  block_base;
		logic [PREFIX_W-1:0] prefix_len;
		logic                last_of_range;
		logic                empty_range;
		logic [FIELD_W-1:0]  blocks_total;
	} ipcidr_block_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_EMPTY
	} ipcidr_state_t;

endpackage

@@ design/ipcidr_stream_if.sv @@
// ----------------------------------------------------------------------------
// ipcidr_stream_if: valid/ready stream channel
// carries one payload per transfer, source drives valid and data
// ----------------------------------------------------------------------------
interface ipcidr_stream_if #(
	parameter type data_t = logic
);

	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

@@ design/ip_range_to_cidr_split.sv @@
// the range is taken in the idle state, then the walk emits one block per cycle while the output is free
// a new range is taken only after the last block of the previous one is loaded
// a reversed range yields one empty result; output stalls hold the walk
// the pace is set by the single block step unit, reused once per block
// reset clears the sequencer, the output valid and the block counter
// ----------------------------------------------------------------------------
// ip_range_to_cidr_split: ipv4 range to cidr block decomposition
// splits each inclusive range into the minimal run of aligned blocks,
// marks the last block and keeps a wrapping count of emitted blocks
// ----------------------------------------------------------------------------
module ip_range_to_cidr_split #(
	parameter int unsigned ADDR_BITS = ipcidr_pkg::ADDR_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	ipcidr_stream_if.sink   range_in,
	ipcidr_stream_if.source block_out
);

	import ipcidr_pkg::*;

	ipcidr_state_t          state_q, state_d;
	logic [ADDR_BITS-1:0]   cur_q;
	logic [ADDR_BITS:0]     span_q;
	logic [FIELD_W-1:0]     count_q;
	ipcidr_block_t          out_q;
	logic                   out_valid_q;

	logic [ADDR_BITS-1:0]   in_first;
	logic [ADDR_BITS-1:0]   in_last;
	logic                   in_reversed;
	logic                   in_xfer;
	logic                   out_free;
	logic                   load_run;
	logic                   load_empty;

	logic [ADDR_BITS-1:0]   step_cur;
	logic [ADDR_BITS:0]     step_span;
	logic [PREFIX_W-1:0]    step_prefix;
	logic                   step_last;

	// input address decode
	assign in_first    = range_in.data.range_first[ADDR_BITS-1:0];
	assign in_last     = range_in.data.range_last[ADDR_BITS-1:0];
	assign in_reversed = in_first > in_last;
	assign in_xfer     = range_in.valid && range_in.ready;
	assign out_free    = !out_valid_q || block_out.ready;

	// shared block step
	ipcidr_step_unit #(
		.ADDR_BITS (ADDR_BITS)
	) u_step (
		.cur        (cur_q),
		.span       (span_q),
		.next_cur   (step_cur),
		.next_span  (step_span),
		.prefix_len (step_prefix),
		.last_block (step_last)
	);

	// sequencer next state and controls
	always_comb begin
		state_d        = state_q;
		range_in.ready = 1'b0;
		load_run       = 1'b0;
		load_empty     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				range_in.ready = 1'b1;
				if (range_in.valid) begin
					state_d = in_reversed ? ST_EMPTY : ST_RUN;
				end
			end
			ST_RUN: begin
				if (out_free) begin
					load_run = 1'b1;
					if (step_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMPTY: begin
				if (out_free) begin
					load_empty = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register, block counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_run) begin
				count_q <= count_q + 1'b1;
			end
			if (load_run || load_empty) begin
				out_valid_q <= 1'b1;
			end else if (block_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// walk registers: current start and remaining span
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cur_q  <= in_first;
			span_q <= {1'b0, in_last} - {1'b0, in_first} + 1'b1;
		end else if (load_run) begin
			cur_q  <= step_cur;
			span_q <= step_span;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load_run) begin
			out_q.block_base    <= FIELD_W'(cur_q);
			out_q.prefix_len    <= step_prefix;
			out_q.last_of_range <= step_last;
			out_q.empty_range   <= 1'b0;
			out_q.blocks_total  <= count_q + 1'b1;
		end else if (load_empty) begin
			out_q.block_base    <= '0;
			out_q.prefix_len    <= '0;
			out_q.last_of_range <= 1'b1;
			out_q.empty_range   <= 1'b1;
			out_q.blocks_total  <= count_q;
		end
	end

	assign block_out.valid = out_valid_q;
	assign block_out.data  = out_q;

	// a walk in progress always has addresses left to cover
	a_span_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> span_q != '0)
		else $error("walk running with empty span");

	// the block that ends the span returns the sequencer to idle
	a_last_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		load_run && step_last |=> state_q == ST_IDLE)
		else $error("walk did not end after last block");

	// a reversed range transfer yields exactly one empty result next
	a_empty_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && in_reversed |=> state_q == ST_EMPTY && $stable(count_q))
		else $error("reversed range not routed to empty result");

	// the counter moves only when a real block is loaded
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!load_run |=> $stable(count_q))
		else $error("block counter moved without a block");

endmodule

@@ design/ipcidr_step_unit.sv @@
// ----------------------------------------------------------------------------
// ipcidr_step_unit: one cidr block step
// picks the largest aligned block at the current start that fits the span
// and gives the advanced start and remaining span
// ----------------------------------------------------------------------------
module ipcidr_step_unit #(
	parameter int unsigned ADDR_BITS = ipcidr_pkg::ADDR_BITS_DEF
) (
	input  logic [ADDR_BITS-1:0]            cur,
	input  logic [ADDR_BITS:0]              span,
	output logic [ADDR_BITS-1:0]            next_cur,
	output logic [ADDR_BITS:0]              next_span,
	output logic [ipcidr_pkg::PREFIX_W-1:0] prefix_len,
	output logic                            last_block
);

	import ipcidr_pkg::*;

	logic [ADDR_BITS:0]    cur_ext;
	logic [ADDR_BITS:0]    low_bit;
	logic [ADDR_BITS:0]    smear;
	logic [ADDR_BITS:0]    top_bit;
	logic [ADDR_BITS:0]    size;
	logic [PREFIX_W-1:0]   expo;

	// lowest set bit of the start, a zero start counts as the whole space
	assign cur_ext = {1'b0, cur};
	always_comb begin
		low_bit = cur_ext & (~cur_ext + 1'b1);
		if (cur == '0) begin
			low_bit = '0;
			low_bit[ADDR_BITS] = 1'b1;
		end
	end

	// highest set bit of the span by or-smearing to the right
	always_comb begin
		smear = span;
		for (int i = 0; i < 6; i++) begin
			if ((1 << i) <= ADDR_BITS) begin
				smear = smear | (smear >> (1 << i));
			end
		end
		top_bit = smear ^ (smear >> 1);
	end

	// both are one-hot, the smaller one is the block size
	assign size = (low_bit < top_bit) ? low_bit : top_bit;

	// encode the one-hot size into its exponent
	always_comb begin
		expo = '0;
		for (int j = 0; j <= ADDR_BITS; j++) begin
			if (size[j]) begin
				expo = expo | PREFIX_W'(j);
			end
		end
	end

	assign prefix_len = PREFIX_W'(ADDR_BITS) - expo;
	assign next_cur   = cur + size[ADDR_BITS-1:0];
	assign next_span  = span - size;
	assign last_block = (span == size);

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: range to cidr splitter check
// drives inclusive address ranges through the input channel, predicts the
// cidr blocks of each range with a local splitter and compares every block
// transfer on the output channel field by field, under random idling
// ----------------------------------------------------------------------------
module testbench;

	import ipcidr_pkg::*;

	localparam int unsigned IDLE_LIMIT   = 2000;
	localparam int unsigned RANDOM_RANGES = 480;
	localparam int unsigned DRAIN_CYCLES = 80;

	typedef ipcidr_block_t block_list_t[$];

	// one directed range, with a typed-in block where it is obvious
	typedef struct {
		logic [FIELD_W-1:0] first;
		logic [FIELD_W-1:0] last;
		bit                 typed;
		ipcidr_block_t      want;
	} cidr_case_t;

	localparam ipcidr_block_t NO_BLOCK = '0;

	logic clk = 1'b0;
	logic arst_n;
	logic steady;

	ipcidr_stream_if #(.data_t(ipcidr_range_t)) range_if ();
	ipcidr_stream_if #(.data_t(ipcidr_block_t)) block_if ();

	ip_range_to_cidr_split dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.range_in  (range_if),
		.block_out (block_if)
	);

	ipcidr_block_t pending_blocks[$];
	logic [FIELD_W-1:0] blocks_emitted;
	int unsigned mismatch_count = 0;
	int unsigned idle_cycles = 0;

	// directed ranges: single addresses, whole space, top, reversed, worst case
	cidr_case_t directed_cases [20] = '{
		'{32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 6'd32, 1'b1, 1'b0, 32'd1}},
		'{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 6'd0, 1'b1, 1'b0, 32'd2}},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 6'd32, 1'b1, 1'b0, 32'd3}},
		'{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0000_0000, 6'd0, 1'b1, 1'b1, 32'd3}},
		'{32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h8000_0000, 6'd1, 1'b1, 1'b0, 32'd4}},
		'{32'h0000_0000, 32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, 6'd1, 1'b1, 1'b0, 32'd5}},
		'{32'h0000_0001, 32'h0000_0000, 1'b1, '{32'h0000_0000, 6'd0, 1'b1, 1'b1, 32'd5}},
		'{32'hC0A8_0000, 32'hC0A8_FFFF, 1'b1, '{32'hC0A8_0000, 6'd16, 1'b1, 1'b0, 32'd6}},
		'{32'h0000_0001, 32'hFFFF_FFFE, 1'b0, NO_BLOCK},
		'{32'h0000_0000, 32'hFFFF_FFFE, 1'b0, NO_BLOCK},
		'{32'h0000_0001, 32'hFFFF_FFFF, 1'b0, NO_BLOCK},
		'{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, NO_BLOCK},
		'{32'h0A00_0001, 32'h0A00_00FE, 1'b0, NO_BLOCK},
		'{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, NO_BLOCK},
		'{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, NO_BLOCK},
		'{32'h0000_0003, 32'h0000_0004, 1'b0, NO_BLOCK},
		'{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, NO_BLOCK},
		'{32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b0, NO_BLOCK},
		'{32'h0000_0000, 32'h0000_0000, 1'b0, NO_BLOCK},
		'{32'h1234_5678, 32'h1234_5678, 1'b0, NO_BLOCK}
	};

	always #5 clk = ~clk;

	// splits one range into its cidr blocks and advances the block count
	function automatic block_list_t split_range(input logic [FIELD_W-1:0] first,
			input logic [FIELD_W-1:0] last);
		block_list_t blocks;
		ipcidr_block_t blk;
		logic [FIELD_W:0] cur;
		logic [FIELD_W:0] top;
		logic [FIELD_W:0] span;
		logic [FIELD_W:0] next_cur;
		int tz;
		int lg;
		int nb;
		cur = {1'b0, first};
		top = {1'b0, last};
		// reversed range: one flagged result, count unchanged
		if (cur > top) begin
			blk = '0;
			blk.last_of_range = 1'b1;
			blk.empty_range = 1'b1;
			blk.blocks_total = blocks_emitted;
			blocks.push_back(blk);
			return blocks;
		end
		while (cur <= top) begin
			span = top - cur + 1'b1;
			// a zero start counts as fully aligned
			tz = ADDR_BITS_DEF;
			for (int i = FIELD_W - 1; i >= 0; i--) begin
				if (cur[i]) tz = i;
			end
			lg = 0;
			for (int i = 0; i <= FIELD_W; i++) begin
				if (span[i]) lg = i;
			end
			nb = (tz < lg) ? tz : lg;
			next_cur = cur + ({{FIELD_W{1'b0}}, 1'b1} << nb);
			blocks_emitted = blocks_emitted + 1'b1;
			blk.block_base = cur[FIELD_W-1:0];
			blk.prefix_len = PREFIX_W'(ADDR_BITS_DEF - nb);
			blk.last_of_range = (next_cur > top);
			blk.empty_range = 1'b0;
			blk.blocks_total = blocks_emitted;
			blocks.push_back(blk);
			cur = next_cur;
		end
		return blocks;
	endfunction

	// one range transfer, then the expected blocks, then maybe a gap
	task automatic send_range(input logic [FIELD_W-1:0] first, input logic [FIELD_W-1:0] last,
			input bit typed, input ipcidr_block_t want);
		block_list_t blocks;
		range_if.valid <= 1'b1;
		range_if.data <= '{range_first: first, range_last: last};
		do @(posedge clk); while (!range_if.ready);
		blocks = split_range(first, last);
		if (typed) begin
			pending_blocks.push_back(want);
		end else begin
			foreach (blocks[i]) pending_blocks.push_back(blocks[i]);
		end
		if (!steady && $urandom_range(99) < 15) begin
			range_if.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// output stalls, none in the steady stretch
	always @(posedge clk) begin
		block_if.ready <= arst_n && (steady || $urandom_range(99) >= 15);
	end

	// compare each block transfer with the oldest expected block
	always @(posedge clk) begin : check_blocks
		ipcidr_block_t got;
		ipcidr_block_t want;
		if (arst_n && block_if.valid && block_if.ready) begin
			got = block_if.data;
			if (pending_blocks.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected block: base %h /%0d last %b empty %b total %0d",
						got.block_base, got.prefix_len, got.last_of_range,
						got.empty_range, got.blocks_total);
				mismatch_count++;
			end else begin
				want = pending_blocks.pop_front();
				if (got.block_base !== want.block_base || got.prefix_len !== want.prefix_len ||
						got.last_of_range !== want.last_of_range ||
						got.empty_range !== want.empty_range ||
						got.blocks_total !== want.blocks_total) begin
					if (mismatch_count < 10)
						$display({"block mismatch: expected base %h /%0d last %b empty %b ",
							"total %0d, got base %h /%0d last %b empty %b total %0d"},
							want.block_base, want.prefix_len, want.last_of_range,
							want.empty_range, want.blocks_total, got.block_base,
							got.prefix_len, got.last_of_range, got.empty_range,
							got.blocks_total);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (range_if.valid && range_if.ready) ||
				(block_if.valid && block_if.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// reset, directed ranges, random ranges, drain
	initial begin
		logic [FIELD_W-1:0] first;
		logic [FIELD_W-1:0] last;
		logic [FIELD_W:0] wide;
		int unsigned sel;
		int unsigned k;
		arst_n = 1'b0;
		steady = 1'b0;
		range_if.valid = 1'b0;
		range_if.data = '0;
		blocks_emitted = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_cases[i])
			send_range(directed_cases[i].first, directed_cases[i].last,
				directed_cases[i].typed, directed_cases[i].want);

		for (int n = 0; n < RANDOM_RANGES; n++) begin
			steady <= (n >= 150 && n < 270);
			sel = $urandom_range(99);
			if (sel < 45) begin
				// short ranges anywhere, clipped at the top address
				first = $urandom;
				wide = {1'b0, first} + $urandom_range(300);
				last = wide[FIELD_W] ? 32'hFFFF_FFFF : wide[FIELD_W-1:0];
			end else if (sel < 60) begin
				// aligned blocks of every size, sometimes off by one
				k = $urandom_range(32);
				wide = ({{FIELD_W{1'b0}}, 1'b1} << k) - 1'b1;
				first = $urandom & ~wide[FIELD_W-1:0];
				last = first | wide[FIELD_W-1:0];
				if ($urandom_range(3) == 0) first = first + 1'b1;
				if ($urandom_range(3) == 0) last = last - 1'b1;
			end else if (sel < 72) begin
				// reversed ranges
				first = $urandom | 32'h1;
				last = $urandom_range(first - 1'b1);
			end else if (sel < 85) begin
				// fully random ends, long runs or reversed
				first = $urandom;
				last = $urandom;
			end else if ($urandom_range(1) == 1) begin
				// ranges reaching the top address
				first = 32'hFFFF_FFFF - $urandom_range(1000);
				last = 32'hFFFF_FFFF;
			end else begin
				// ranges starting at or near zero
				first = $urandom_range(3);
				last = $urandom >> $urandom_range(31);
			end
			send_range(first, last, 1'b0, NO_BLOCK);
		end
		range_if.valid <= 1'b0;
		steady <= 1'b0;

		while (pending_blocks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ files.f @@
design/ipcidr_pkg.sv
design/ipcidr_stream_if.sv
design/ipcidr_step_unit.sv
design/ip_range_to_cidr_split.sv
test/testbench.sv
